@@ src/serial_mono_lcd_controller_assert.svh @@
// assertion macros for the serial mono lcd controller
// used by the top level, expects clk and rst in scope
`ifndef SERIAL_MONO_LCD_CONTROLLER_ASSERT_SVH
`define SERIAL_MONO_LCD_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define SLCD_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define SLCD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ src/slcd_pkg.sv @@
// shared types and constants for the serial mono lcd controller
// no dependencies
`timescale 1ns / 1ps

package slcd_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int BANK_W = 3;

  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // command byte decode
  localparam logic [7:0] CMD_FSET_MASK = 8'hF8;
  localparam logic [7:0] CMD_FSET      = 8'h20;
  localparam logic [7:0] CMD_DCTL_MASK = 8'hFA;
  localparam logic [7:0] CMD_DCTL      = 8'h08;
  localparam logic [7:0] CMD_SETY_MASK = 8'hF8;
  localparam logic [7:0] CMD_SETY      = 8'h40;

  typedef struct packed {
    logic e;
    logic d;
    logic pd;
    logic v;
    logic h;
  } mode_t;

  localparam mode_t MODE_RESET = '{e: 1'b0, d: 1'b0, pd: 1'b1, v: 1'b0, h: 1'b0};

  typedef struct packed {
    logic reset_n;
    logic chip_select_n;
    logic serial_clock;
    logic data_not_command;
    logic serial_data;
  } pin_t;

  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  col;
    logic [BANK_W-1:0] bank;
    logic [7:0]        data;
  } ram_write_t;

endpackage

@@ src/slcd_in_if.sv @@
// input channel: pin samples and pixel reads
// depends on slcd_pkg
`timescale 1ns / 1ps

interface slcd_in_if import slcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic             reset_n;
  logic             chip_select_n;
  logic             serial_clock;
  logic             data_not_command;
  logic             serial_data;
  logic [COL_W-1:0] pixel_column;
  logic [ROW_W-1:0] pixel_row;

  modport source (
    output valid, op, reset_n, chip_select_n, serial_clock, data_not_command,
           serial_data, pixel_column, pixel_row,
    input  ready
  );
  modport sink (
    input  valid, op, reset_n, chip_select_n, serial_clock, data_not_command,
           serial_data, pixel_column, pixel_row,
    output ready
  );
endinterface

@@ src/slcd_out_if.sv @@
// output channel: one pixel beat per read
// depends on slcd_pkg
`timescale 1ns / 1ps

interface slcd_out_if import slcd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       pixel_on;
  logic       power_down;
  logic [1:0] display_mode;
  logic       vertical_addressing;

  modport source (
    output valid, pixel_on, power_down, display_mode, vertical_addressing,
    input  ready
  );
  modport sink (
    input  valid, pixel_on, power_down, display_mode, vertical_addressing,
    output ready
  );
endinterface

@@ src/serial_mono_lcd_controller.sv @@
// Serial monochrome LCD controller. One beat on req is either a pin sample
// (op 0) that drives the serial shifter, command decoder and display ram
// writes, or a pixel read (op 1) that returns one beat on rsp with the shown
// pixel and the current mode flags. An item can be taken every cycle while
// the ram is not being cleared and rsp is not stalled. A read passes the
// input register, the registered read of the display ram (one write port,
// one registered read port) and the output register. After rst the ram
// is swept to zero one byte per cycle, all COLUMNS*BANKS bytes (504 by
// default), and req is held not ready until the sweep ends. The reset pin
// (reset_n low) resets pointers, shifter and flags but leaves the ram alone.
// depends on slcd_pkg, slcd_in_if, slcd_out_if, slcd_ram, slcd_ctrl
`timescale 1ns / 1ps

`include "serial_mono_lcd_controller_assert.svh"

module serial_mono_lcd_controller import slcd_pkg::*; #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input logic       clk,
  input logic       rst,
  slcd_in_if.sink   req,
  slcd_out_if.source rsp
);

  localparam int DEPTH = COLUMNS * BANKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [COL_W:0]   COLS_LIM  = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]   ROWS_LIM  = (ROW_W + 1)'(8 * BANKS);

  // ram clearing sweep after reset
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // input register stage
  logic             a_valid;
  logic             a_op;
  pin_t             a_pins;
  logic [COL_W-1:0] a_col;
  logic [ROW_W-1:0] a_row;

  // ram read stage
  logic       b_valid;
  logic       b_in_range;
  logic [2:0] b_bit;
  mode_t      b_mode;

  // output register
  logic       o_valid;
  logic       o_pixel;
  logic       o_pd;
  logic [1:0] o_mode;
  logic       o_v;

  logic       o_free, b_free, b_adv, a_leave, a_read_go, a_pin_go, accept;
  mode_t      mode;
  ram_write_t ctrl_wr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_q;
  logic          ram_bit;
  logic          pixel;

  // handshake chain: a stalled output only stalls reads, pin samples drain
  assign o_free    = !o_valid || rsp.ready;
  assign b_free    = !b_valid || o_free;
  assign b_adv     = b_valid && o_free;
  assign a_pin_go  = a_valid && (a_op == OP_PIN);
  assign a_read_go = a_valid && (a_op == OP_READ) && b_free;
  assign a_leave   = a_pin_go || a_read_go;
  assign req.ready = !clearing && (!a_valid || a_leave);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_leave) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op                    <= req.op;
      a_pins.reset_n          <= req.reset_n;
      a_pins.chip_select_n    <= req.chip_select_n;
      a_pins.serial_clock     <= req.serial_clock;
      a_pins.data_not_command <= req.data_not_command;
      a_pins.serial_data      <= req.serial_data;
      a_col                   <= req.pixel_column;
      a_row                   <= req.pixel_row;
    end
  end

  slcd_ctrl #(
    .COLUMNS(COLUMNS),
    .BANKS  (BANKS)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .en  (a_pin_go),
    .pins(a_pins),
    .mode(mode),
    .wr  (ctrl_wr)
  );

  // bank-major byte address: bank * COLUMNS + column
  assign ram_we    = clearing || ctrl_wr.en;
  assign ram_waddr = clearing ? clr_addr
                              : AW'(32'(ctrl_wr.bank) * 32'(COLUMNS) + 32'(ctrl_wr.col));
  assign ram_wdata = clearing ? 8'h00 : ctrl_wr.data;
  assign ram_raddr = AW'(32'(a_row[ROW_W-1:3]) * 32'(COLUMNS) + 32'(a_col));

  slcd_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (a_read_go),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // flags are captured as the read leaves the input register, after every
  // earlier pin sample has taken effect
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_read_go) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_read_go) begin
      b_in_range <= ({1'b0, a_col} < COLS_LIM) && ({1'b0, a_row} < ROWS_LIM);
      b_bit      <= a_row[2:0];
      b_mode     <= mode;
    end
  end

  // display rules: power down dark-off, then blank / all on / normal / inverse
  assign ram_bit = b_in_range && ram_q[b_bit];
  always_comb begin
    if (b_mode.pd) begin
      pixel = 1'b0;
    end else if (!b_mode.d) begin
      pixel = b_mode.e;
    end else begin
      pixel = ram_bit ^ b_mode.e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (b_adv) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      o_pixel <= pixel;
      o_pd    <= b_mode.pd;
      o_mode  <= {b_mode.d, b_mode.e};
      o_v     <= b_mode.v;
    end
  end

  assign rsp.valid               = o_valid;
  assign rsp.pixel_on            = o_pixel;
  assign rsp.power_down          = o_pd;
  assign rsp.display_mode        = o_mode;
  assign rsp.vertical_addressing = o_v;

  // pipeline stays empty for the whole sweep
  `SLCD_ASSERT_IMPL(a_clear_empty, clearing, !a_valid && !b_valid && !o_valid, "busy while clearing")
  // a pending read keeps its ram data while the output is stalled
  `SLCD_ASSERT_NEXT(a_b_hold, b_valid && !o_free, b_valid && $stable(ram_q), "ram data lost")
  // ram write and read never share a cycle
  `SLCD_ASSERT_IMPL(a_port_excl, ram_we, !a_read_go, "ram write with read")
  // the write pointer stays inside the panel
  `SLCD_ASSERT_IMPL(a_col_range, ctrl_wr.en, {1'b0, ctrl_wr.col} < COLS_LIM, "column out of range")

endmodule

@@ src/slcd_ram.sv @@
// display ram, one write port and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module slcd_ram #(
  parameter int DEPTH = 504,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/slcd_ctrl.sv @@
// serial shifter, command decoder, address pointers and mode flags
// depends on slcd_pkg
`timescale 1ns / 1ps

module slcd_ctrl import slcd_pkg::*; #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  pin_t       pins,
  output mode_t      mode,
  output ram_write_t wr
);

  localparam logic [COL_W:0]  COLS_LIM  = (COL_W + 1)'(COLUMNS);
  localparam logic [BANK_W:0] BANKS_LIM = (BANK_W + 1)'(BANKS);

  logic [7:0]        shift_byte, shift_byte_next;
  logic [2:0]        bit_count, bit_count_next;
  logic              last_clock_high, last_clock_high_next;
  logic [COL_W-1:0]  column_pointer, column_pointer_next;
  logic [BANK_W-1:0] bank_pointer, bank_pointer_next;
  mode_t             mode_flags, mode_flags_next;

  logic [7:0]        byte_in;
  logic [COL_W:0]    col_inc;
  logic [BANK_W:0]   bank_inc;

  assign byte_in  = {shift_byte[7:1], pins.serial_data};
  assign col_inc  = {1'b0, column_pointer} + 1'b1;
  assign bank_inc = {1'b0, bank_pointer} + 1'b1;

  always_comb begin
    shift_byte_next      = shift_byte;
    bit_count_next       = bit_count;
    last_clock_high_next = last_clock_high;
    column_pointer_next  = column_pointer;
    bank_pointer_next    = bank_pointer;
    mode_flags_next      = mode_flags;
    wr.en                = 1'b0;
    wr.col               = column_pointer;
    wr.bank              = bank_pointer;
    wr.data              = byte_in;

    if (en) begin
      if (!pins.reset_n) begin
        shift_byte_next     = '0;
        bit_count_next      = '0;
        column_pointer_next = '0;
        bank_pointer_next   = '0;
        mode_flags_next     = MODE_RESET;
      end else if (pins.chip_select_n) begin
        shift_byte_next = '0;
        bit_count_next  = '0;
      end else if (!pins.serial_clock) begin
        last_clock_high_next = 1'b0;
      end else if (!last_clock_high) begin
        last_clock_high_next = 1'b1;
        if (bit_count == 3'd7) begin
          shift_byte_next = byte_in;
          bit_count_next  = '0;
          if (pins.data_not_command) begin
            wr.en = 1'b1;
            // pointer advance with wrap
            if (mode_flags.v) begin
              if (bank_inc >= BANKS_LIM) begin
                bank_pointer_next = '0;
                if (col_inc >= COLS_LIM) begin
                  column_pointer_next = '0;
                end else begin
                  column_pointer_next = col_inc[COL_W-1:0];
                end
              end else begin
                bank_pointer_next = bank_inc[BANK_W-1:0];
              end
            end else begin
              if (col_inc >= COLS_LIM) begin
                column_pointer_next = '0;
                if (bank_inc >= BANKS_LIM) begin
                  bank_pointer_next = '0;
                end else begin
                  bank_pointer_next = bank_inc[BANK_W-1:0];
                end
              end else begin
                column_pointer_next = col_inc[COL_W-1:0];
              end
            end
          end else begin
            // command decode; only function set is decoded while h is set
            if ((byte_in & CMD_FSET_MASK) == CMD_FSET) begin
              mode_flags_next.h  = byte_in[0];
              mode_flags_next.v  = byte_in[1];
              mode_flags_next.pd = byte_in[2];
            end else if (!mode_flags.h) begin
              if ((byte_in & CMD_DCTL_MASK) == CMD_DCTL) begin
                mode_flags_next.d = byte_in[2];
                mode_flags_next.e = byte_in[0];
              end else if ((byte_in & CMD_SETY_MASK) == CMD_SETY) begin
                if ({1'b0, byte_in[BANK_W-1:0]} < BANKS_LIM) begin
                  bank_pointer_next = byte_in[BANK_W-1:0];
                end
              end else if (byte_in[7]) begin
                if ({1'b0, byte_in[COL_W-1:0]} < COLS_LIM) begin
                  column_pointer_next = byte_in[COL_W-1:0];
                end
              end
            end
          end
        end else begin
          shift_byte_next = {byte_in[6:0], 1'b0};
          bit_count_next  = bit_count + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte      <= '0;
      bit_count       <= '0;
      last_clock_high <= 1'b0;
      column_pointer  <= '0;
      bank_pointer    <= '0;
      mode_flags      <= MODE_RESET;
    end else begin
      shift_byte      <= shift_byte_next;
      bit_count       <= bit_count_next;
      last_clock_high <= last_clock_high_next;
      column_pointer  <= column_pointer_next;
      bank_pointer    <= bank_pointer_next;
      mode_flags      <= mode_flags_next;
    end
  end

  assign mode = mode_flags;

endmodule
